>>> design/driven_lattice_gas_metropolis_unit_assert.svh
// Assertion macros used by the lattice gas move engine sequencer.
`ifndef DRIVEN_LATTICE_GAS_METROPOLIS_UNIT_ASSERT_SVH
`define DRIVEN_LATTICE_GAS_METROPOLIS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define DLG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled during reset
`define DLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DLG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> design/dlg_pkg.sv
// Shared types, constants and codes of the lattice gas move engine.
`timescale 1ns / 1ps
`default_nettype none

package dlg_pkg;

    // lattice geometry
    localparam int ROWS   = 128;
    localparam int COLS   = 1024;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(DEPTH);

    // channel field widths
    localparam int SITE_ROW_W = 7;
    localparam int SITE_COL_W = 10;
    localparam int DIR_W      = 2;
    localparam int FRAC_W     = 32;
    localparam int KIND_W     = 2;
    localparam int DELTA_W    = 3;
    localparam int BAND_W     = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Metropolis table and read schedule
    localparam int NUM_PROB    = 3;
    localparam int READS_RIGHT = 2;
    localparam int READS_VERT  = 8;
    localparam int STEP_W      = $clog2(READS_VERT);

    // register reset values
    localparam logic [FRAC_W-1:0] PROB_LOW_M1_RST  = 32'd1230528725;
    localparam logic [FRAC_W-1:0] PROB_LOW_M2_RST  = 32'd352552391;
    localparam logic [FRAC_W-1:0] PROB_LOW_M3_RST  = 32'd101007752;
    localparam logic [FRAC_W-1:0] PROB_HIGH_M1_RST = 32'd2605029521;
    localparam logic [FRAC_W-1:0] PROB_HIGH_M2_RST = 32'd1580029991;
    localparam logic [FRAC_W-1:0] PROB_HIGH_M3_RST = 32'd958336912;

    typedef enum logic [DIR_W-1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } hop_dir_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 2'd0,
        KIND_RIGHT = 2'd1,
        KIND_UP    = 2'd2,
        KIND_DOWN  = 2'd3
    } hop_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROB_LOW_M1  = 4'd0,
        REG_PROB_LOW_M2  = 4'd1,
        REG_PROB_LOW_M3  = 4'd2,
        REG_PROB_HIGH_M1 = 4'd3,
        REG_PROB_HIGH_M2 = 4'd4,
        REG_PROB_HIGH_M3 = 4'd5,
        REG_BAND_FIRST   = 4'd6,
        REG_BAND_END     = 4'd7
    } cfg_idx_t;

    // configuration seen by the engine
    typedef struct packed {
        logic [NUM_PROB-1:0][FRAC_W-1:0] prob_low;
        logic [NUM_PROB-1:0][FRAC_W-1:0] prob_high;
        logic [BAND_W-1:0]               band_first;
        logic [BAND_W-1:0]               band_end;
    } cfg_regs_t;

    // one lattice access from the sequencer
    typedef struct packed {
        logic             en;
        logic             we;
        logic             wdata;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } site_req_t;

endpackage

`default_nettype wire

>>> design/dlg_ifs.sv
// Valid/ready channel interfaces: move attempts, move results, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface dlg_item_if;
    logic                            valid;
    logic                            ready;
    logic [dlg_pkg::SITE_ROW_W-1:0]  site_row;
    logic [dlg_pkg::SITE_COL_W-1:0]  site_col;
    logic [dlg_pkg::DIR_W-1:0]       hop_dir;
    logic [dlg_pkg::FRAC_W-1:0]      rand_frac;

    modport source (output valid, site_row, site_col, hop_dir, rand_frac, input ready);
    modport sink   (input valid, site_row, site_col, hop_dir, rand_frac, output ready);
endinterface

interface dlg_result_if;
    logic                                valid;
    logic                                ready;
    logic                                hop_done;
    logic [dlg_pkg::KIND_W-1:0]          hop_kind;
    logic [dlg_pkg::SITE_COL_W-1:0]      current_col;
    logic signed [dlg_pkg::DELTA_W-1:0]  energy_delta;

    modport source (output valid, hop_done, hop_kind, current_col, energy_delta,
                    input ready);
    modport sink   (input valid, hop_done, hop_kind, current_col, energy_delta,
                    output ready);
endinterface

interface dlg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dlg_pkg::CFG_IDX_W-1:0]    idx;
    logic [dlg_pkg::CFG_DATA_W-1:0]   wdata;

    modport source (output valid, idx, wdata, input ready);
    modport sink   (input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

>>> design/dlg_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module dlg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one access per cycle: write, or read into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/dlg_cfg_regs.sv
// Configuration register file: Metropolis tables and hot band limits.
`timescale 1ns / 1ps
`default_nettype none

module dlg_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    dlg_cfg_if.sink           cfg,
    output dlg_pkg::cfg_regs_t regs
);

    import dlg_pkg::*;

    logic [NUM_PROB-1:0][FRAC_W-1:0] prob_low_reg;
    logic [NUM_PROB-1:0][FRAC_W-1:0] prob_high_reg;
    logic [BAND_W-1:0]               band_first_reg;
    logic [BAND_W-1:0]               band_end_reg;

    // writes always complete; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_low_reg[0]  <= PROB_LOW_M1_RST;
            prob_low_reg[1]  <= PROB_LOW_M2_RST;
            prob_low_reg[2]  <= PROB_LOW_M3_RST;
            prob_high_reg[0] <= PROB_HIGH_M1_RST;
            prob_high_reg[1] <= PROB_HIGH_M2_RST;
            prob_high_reg[2] <= PROB_HIGH_M3_RST;
            band_first_reg   <= '0;
            band_end_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.idx)
                REG_PROB_LOW_M1:  prob_low_reg[0]  <= cfg.wdata[FRAC_W-1:0];
                REG_PROB_LOW_M2:  prob_low_reg[1]  <= cfg.wdata[FRAC_W-1:0];
                REG_PROB_LOW_M3:  prob_low_reg[2]  <= cfg.wdata[FRAC_W-1:0];
                REG_PROB_HIGH_M1: prob_high_reg[0] <= cfg.wdata[FRAC_W-1:0];
                REG_PROB_HIGH_M2: prob_high_reg[1] <= cfg.wdata[FRAC_W-1:0];
                REG_PROB_HIGH_M3: prob_high_reg[2] <= cfg.wdata[FRAC_W-1:0];
                REG_BAND_FIRST:   band_first_reg   <= cfg.wdata[BAND_W-1:0];
                REG_BAND_END:     band_end_reg     <= cfg.wdata[BAND_W-1:0];
                default:          ;
            endcase
        end
    end

    assign regs.prob_low   = prob_low_reg;
    assign regs.prob_high  = prob_high_reg;
    assign regs.band_first = band_first_reg;
    assign regs.band_end   = band_end_reg;

endmodule

`default_nettype wire

>>> design/dlg_addr_gen.sv
// Shared address unit: maps a (row, col) site access onto the lattice RAM.
`timescale 1ns / 1ps
`default_nettype none

module dlg_addr_gen (
    input  dlg_pkg::site_req_t               req,
    output logic                             mem_en,
    output logic                             mem_we,
    output logic                             mem_wdata,
    output logic [dlg_pkg::ADDR_W-1:0]       mem_addr
);

    import dlg_pkg::*;

    // row-major linear address: row * COLS + col
    assign mem_addr  = ADDR_W'(ADDR_W'(req.row) * ADDR_W'(COLS) + ADDR_W'(req.col));
    assign mem_en    = req.en;
    assign mem_we    = req.we;
    assign mem_wdata = req.wdata;

endmodule

`default_nettype wire

>>> design/dlg_seq.sv
// Move sequencer: lattice init sweep, neighbor reads, Metropolis decision, hop writes.
`timescale 1ns / 1ps
`default_nettype none
`include "driven_lattice_gas_metropolis_unit_assert.svh"

module dlg_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    dlg_item_if.sink           item,
    dlg_result_if.source       result,
    input  dlg_pkg::cfg_regs_t cfg_regs,
    output dlg_pkg::site_req_t req,
    input  wire logic          mem_rdata
);

    import dlg_pkg::*;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_DRAIN  = 8'b0000_1000,
        S_DECIDE = 8'b0001_0000,
        S_WR0    = 8'b0010_0000,
        S_WR1    = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } state_t;

    function automatic logic [ROW_W-1:0] row_up(input logic [ROW_W-1:0] r);
        row_up = (r == '0) ? ROW_W'(ROWS - 1) : r - 1'b1;
    endfunction

    function automatic logic [ROW_W-1:0] row_down(input logic [ROW_W-1:0] r);
        row_down = (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
    endfunction

    function automatic logic [COL_W-1:0] col_prev(input logic [COL_W-1:0] c);
        col_prev = (c == '0) ? COL_W'(COLS - 1) : c - 1'b1;
    endfunction

    function automatic logic [COL_W-1:0] col_next(input logic [COL_W-1:0] c);
        col_next = (c == COL_W'(COLS - 1)) ? '0 : c + 1'b1;
    endfunction

    // control state
    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    init_row_reg, init_row_next;
    logic [COL_W-1:0]    init_col_reg, init_col_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                rd_cap_reg, rd_cap_next;
    logic                out_valid_reg, out_valid_next;

    // per-attempt payload
    logic [ROW_W-1:0]    row_reg, tgt_reg, opp_reg, far_reg;
    logic [COL_W-1:0]    col_reg, cp_reg, cn_reg;
    hop_dir_t            dir_reg;
    logic [FRAC_W-1:0]   rnd_reg;
    logic [STEP_W-1:0]   rd_idx_reg;
    logic [READS_VERT-1:0] rd_bits_reg;

    logic                   pend_done_reg, pend_done_next;
    hop_kind_t              pend_kind_reg, pend_kind_next;
    logic [SITE_COL_W-1:0]  pend_col_reg, pend_col_next;
    logic signed [DELTA_W-1:0] pend_delta_reg, pend_delta_next;

    logic                   out_done_reg;
    hop_kind_t              out_kind_reg;
    logic [SITE_COL_W-1:0]  out_col_reg;
    logic signed [DELTA_W-1:0] out_delta_reg;

    // accept-time decode
    logic                in_range;
    logic                item_fire;
    logic                out_load;
    hop_dir_t            in_dir;
    logic [ROW_W-1:0]    in_row;
    logic [COL_W-1:0]    in_col;
    logic [ROW_W-1:0]    in_up, in_down;

    // read schedule
    logic [STEP_W-1:0]   last_step;
    logic [ROW_W-1:0]    rd_row;
    logic [COL_W-1:0]    rd_col;

    // decision
    logic [1:0]                d_e_old, d_e_new;
    logic signed [DELTA_W-1:0] d_delta;
    logic [DELTA_W-1:0]        d_mag;
    logic                      d_neg, d_hot, d_vert, d_open, d_pass, d_done;
    logic [FRAC_W-1:0]         d_prob;
    hop_kind_t                 d_kind;

    assign item.ready = (state_reg == S_IDLE);
    assign item_fire  = item.valid && item.ready;

    assign in_dir   = hop_dir_t'(item.hop_dir);
    assign in_row   = ROW_W'(item.site_row);
    assign in_col   = COL_W'(item.site_col);
    assign in_up    = row_up(in_row);
    assign in_down  = row_down(in_row);
    assign in_range = (32'(item.site_row) < ROWS) && (32'(item.site_col) < COLS);

    assign last_step = (dir_reg == DIR_RIGHT) ? STEP_W'(READS_RIGHT - 1)
                                              : STEP_W'(READS_VERT - 1);

    // site visited at each read step; step 0 is the origin, step 1 the target
    always_comb
    begin
        rd_row = row_reg;
        rd_col = col_reg;
        case (step_reg)
            3'd0:
            begin
                rd_row = row_reg;
                rd_col = col_reg;
            end
            3'd1:
            begin
                rd_row = (dir_reg == DIR_RIGHT) ? row_reg : tgt_reg;
                rd_col = (dir_reg == DIR_RIGHT) ? cn_reg  : col_reg;
            end
            3'd2:
            begin
                rd_row = opp_reg;
                rd_col = col_reg;
            end
            3'd3:
            begin
                rd_row = row_reg;
                rd_col = cp_reg;
            end
            3'd4:
            begin
                rd_row = row_reg;
                rd_col = cn_reg;
            end
            3'd5:
            begin
                rd_row = far_reg;
                rd_col = col_reg;
            end
            3'd6:
            begin
                rd_row = tgt_reg;
                rd_col = cp_reg;
            end
            3'd7:
            begin
                rd_row = tgt_reg;
                rd_col = cn_reg;
            end
            default:
            begin
                rd_row = row_reg;
                rd_col = col_reg;
            end
        endcase
    end

    // bond counts and Metropolis test
    assign d_e_old = 2'(rd_bits_reg[2]) + 2'(rd_bits_reg[3]) + 2'(rd_bits_reg[4]);
    assign d_e_new = 2'(rd_bits_reg[5]) + 2'(rd_bits_reg[6]) + 2'(rd_bits_reg[7]);
    assign d_delta = DELTA_W'(d_e_new) - DELTA_W'(d_e_old);
    assign d_neg   = d_delta[DELTA_W-1];
    assign d_mag   = ~d_delta;  // -delta - 1 selects the table entry
    assign d_hot   = (32'(col_reg) >= 32'(cfg_regs.band_first))
                  && (32'(col_reg) <  32'(cfg_regs.band_end));

    always_comb
    begin
        case (d_mag[1:0])
            2'd0:    d_prob = d_hot ? cfg_regs.prob_high[0] : cfg_regs.prob_low[0];
            2'd1:    d_prob = d_hot ? cfg_regs.prob_high[1] : cfg_regs.prob_low[1];
            2'd2:    d_prob = d_hot ? cfg_regs.prob_high[2] : cfg_regs.prob_low[2];
            default: d_prob = '1;
        endcase
    end

    assign d_vert = (dir_reg == DIR_UP) || (dir_reg == DIR_DOWN);
    assign d_open = rd_bits_reg[0] && !rd_bits_reg[1];
    assign d_pass = !d_neg || (rnd_reg < d_prob);
    assign d_done = d_open && ((dir_reg == DIR_RIGHT) || (d_vert && d_pass));

    always_comb
    begin
        case (dir_reg)
            DIR_RIGHT: d_kind = KIND_RIGHT;
            DIR_UP:    d_kind = KIND_UP;
            DIR_DOWN:  d_kind = KIND_DOWN;
            default:   d_kind = KIND_NONE;
        endcase
    end

    assign out_load = (state_reg == S_RESULT) && (!out_valid_reg || result.ready);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        init_row_next   = init_row_reg;
        init_col_next   = init_col_reg;
        step_next       = step_reg;
        rd_cap_next     = 1'b0;
        pend_done_next  = pend_done_reg;
        pend_kind_next  = pend_kind_reg;
        pend_col_next   = pend_col_reg;
        pend_delta_next = pend_delta_reg;
        req             = '0;

        case (state_reg)
            S_INIT:
            begin
                // checkerboard sweep: occupied where row + col is even
                req.en    = 1'b1;
                req.we    = 1'b1;
                req.row   = init_row_reg;
                req.col   = init_col_reg;
                req.wdata = ~(init_row_reg[0] ^ init_col_reg[0]);
                if (init_col_reg == COL_W'(COLS - 1))
                begin
                    init_col_next = '0;
                    if (init_row_reg == ROW_W'(ROWS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        init_row_next = init_row_reg + 1'b1;
                    end
                end
                else
                begin
                    init_col_next = init_col_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (item_fire)
                begin
                    step_next = '0;
                    if (!in_range || (in_dir == DIR_LEFT))
                    begin
                        pend_done_next  = 1'b0;
                        pend_kind_next  = KIND_NONE;
                        pend_col_next   = '0;
                        pend_delta_next = '0;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                req.en      = 1'b1;
                req.row     = rd_row;
                req.col     = rd_col;
                rd_cap_next = 1'b1;
                if (step_reg == last_step)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                pend_done_next  = d_done;
                pend_kind_next  = d_done ? d_kind : KIND_NONE;
                pend_col_next   = d_done ? SITE_COL_W'(col_reg) : '0;
                pend_delta_next = (d_open && d_vert) ? d_delta : '0;
                state_next      = d_done ? S_WR0 : S_RESULT;
            end
            S_WR0:
            begin
                // vacate the origin
                req.en    = 1'b1;
                req.we    = 1'b1;
                req.wdata = 1'b0;
                req.row   = row_reg;
                req.col   = col_reg;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                // fill the target
                req.en    = 1'b1;
                req.we    = 1'b1;
                req.wdata = 1'b1;
                req.row   = (dir_reg == DIR_RIGHT) ? row_reg : tgt_reg;
                req.col   = (dir_reg == DIR_RIGHT) ? cn_reg  : col_reg;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_row_reg  <= '0;
            init_col_reg  <= '0;
            step_reg      <= '0;
            rd_cap_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_row_reg  <= init_row_next;
            init_col_reg  <= init_col_next;
            step_reg      <= step_next;
            rd_cap_reg    <= rd_cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            row_reg <= in_row;
            col_reg <= in_col;
            cp_reg  <= col_prev(in_col);
            cn_reg  <= col_next(in_col);
            dir_reg <= in_dir;
            rnd_reg <= item.rand_frac;
            tgt_reg <= (in_dir == DIR_UP) ? in_up   : in_down;
            opp_reg <= (in_dir == DIR_UP) ? in_down : in_up;
            far_reg <= (in_dir == DIR_UP) ? row_up(in_up) : row_down(in_down);
        end
        if (state_reg == S_READ)
        begin
            rd_idx_reg <= step_reg;
        end
        if (rd_cap_reg)
        begin
            rd_bits_reg[rd_idx_reg] <= mem_rdata;
        end
        pend_done_reg  <= pend_done_next;
        pend_kind_reg  <= pend_kind_next;
        pend_col_reg   <= pend_col_next;
        pend_delta_reg <= pend_delta_next;
        if (out_load)
        begin
            out_done_reg  <= pend_done_reg;
            out_kind_reg  <= pend_kind_reg;
            out_col_reg   <= pend_col_reg;
            out_delta_reg <= pend_delta_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.hop_done     = out_done_reg;
    assign result.hop_kind     = out_kind_reg;
    assign result.current_col  = out_col_reg;
    assign result.energy_delta = out_delta_reg;

    // checks
    `DLG_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, item.valid && item.ready, state_reg != S_IDLE, "engine still idle after a transfer")
    `DLG_ASSERT_IMP(a_hop_needs_open_target, clk, rst_n, state_reg == S_WR0, rd_bits_reg[0] && !rd_bits_reg[1], "hop written without occupied origin and empty target")
    `DLG_ASSERT_IMP(a_reads_landed, clk, rst_n, state_reg == S_DECIDE, !rd_cap_reg, "decision taken with a read still in flight")
    `DLG_ASSERT_IMP(a_done_has_kind, clk, rst_n, out_valid_reg && out_done_reg, out_kind_reg != KIND_NONE, "completed hop reported with no kind")
    `DLG_ASSERT_IMP(a_delta_vertical, clk, rst_n, out_valid_reg && out_done_reg && (out_delta_reg != '0), out_kind_reg == KIND_UP || out_kind_reg == KIND_DOWN, "bond change on a non-vertical hop")

endmodule

`default_nettype wire

>>> design/driven_lattice_gas_metropolis_unit.sv
// Driven lattice gas move engine: lattice memory, sequencer and register file.
// Usage:
//   item   - move attempts (site_row, site_col, hop_dir, rand_frac); one transfer
//            per attempt. ready is high only while the engine is idle.
//   result - exactly one transfer per attempt: hop_done, hop_kind, current_col
//            and energy_delta, held in an output register until taken.
//   cfg    - register writes (idx, wdata), always ready; write only while idle.
// Steps from the item transfer to result valid:
//   right hop:             2 reads + drain + decide (+2 writes) + load
//   up/down hop:           8 reads + drain + decide (+2 writes) + load
//   left or off-lattice:   straight to the result load
// Every lattice access goes through the one port of the bit memory, one access
// per cycle; the read count per direction sets the length of each sequence. The
// engine passes through idle again before it takes the next attempt.
// Reset: the registers take their default values at once; then the lattice is
// swept to a checkerboard, one site per cycle over all ROWS*COLS = 131072 sites,
// with item.ready low throughout (cfg writes are still taken).
// A stalled receiver holds the result; the next attempt may be taken meanwhile
// and its result waits in the engine until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module driven_lattice_gas_metropolis_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    dlg_item_if.sink     item,
    dlg_result_if.source result,
    dlg_cfg_if.sink      cfg
);

    import dlg_pkg::*;

    cfg_regs_t          cfg_regs;
    site_req_t          req;
    logic               mem_en;
    logic               mem_we;
    logic               mem_wdata;
    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_rdata;

    dlg_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    dlg_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_regs  (cfg_regs),
        .req       (req),
        .mem_rdata (mem_rdata)
    );

    dlg_addr_gen u_addr (
        .req       (req),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_wdata (mem_wdata),
        .mem_addr  (mem_addr)
    );

    dlg_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_lattice (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the driven lattice gas move engine.
`timescale 1ns / 1ps

module testbench;
    import dlg_pkg::*;

    typedef struct packed {
        logic                      hop_done;
        hop_kind_t                 hop_kind;
        logic [SITE_COL_W-1:0]     current_col;
        logic signed [DELTA_W-1:0] energy_delta;
    } hop_outcome_t;

    // one directed attempt; typed rows carry their own expected outcome
    typedef struct packed {
        logic [SITE_ROW_W-1:0] row;
        logic [SITE_COL_W-1:0] col;
        hop_dir_t              dir;
        logic [FRAC_W-1:0]     frac;
        logic                  typed;
        hop_outcome_t          want;
    } directed_attempt_t;

    localparam hop_outcome_t           NO_HOP        = '{1'b0, KIND_NONE, '0, '0};
    localparam logic [FRAC_W-1:0]      FRAC_MAX      = '1;
    localparam logic [CFG_IDX_W-1:0]   CFG_IDX_SPARE = 4'd8;
    localparam int                     PHASE_HOPS    = 125;
    localparam int                     WIN           = 6;

    logic clk;
    logic rst_n;

    dlg_item_if   move_ch ();
    dlg_result_if outcome_ch ();
    dlg_cfg_if    reg_ch ();

    driven_lattice_gas_metropolis_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (move_ch),
        .result (outcome_ch),
        .cfg    (reg_ch)
    );

    // lattice and register shadow of the engine
    bit                occ [ROWS][COLS];
    logic [FRAC_W-1:0] prob_low  [NUM_PROB];
    logic [FRAC_W-1:0] prob_high [NUM_PROB];
    logic [BAND_W-1:0] band_first;
    logic [BAND_W-1:0] band_end;

    hop_outcome_t hop_outcomes_due [$];

    int send_gap_pct;
    int recv_gap_pct;
    int mismatches;
    int attempts;
    int outcomes_checked;
    int right_hops;
    int vert_hops;
    int uphill_takes;
    int vert_refusals;

    directed_attempt_t directed_rows [16];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("driven_lattice_gas_metropolis_unit regression: fail");
        $finish;
    end

    // result side backpressure
    always @(negedge clk)
    begin
        outcome_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    // compare each result transfer with the oldest outstanding outcome
    always @(posedge clk)
    begin
        hop_outcome_t exp_out;
        if (rst_n && outcome_ch.valid && outcome_ch.ready)
        begin
            if (hop_outcomes_due.size() == 0)
            begin
                $error("result transfer with no outstanding attempt");
                mismatches++;
            end
            else
            begin
                exp_out = hop_outcomes_due.pop_front();
                outcomes_checked++;
                if (outcome_ch.hop_done !== exp_out.hop_done)
                begin
                    $error("hop_done: expected %0d, got %0d",
                           exp_out.hop_done, outcome_ch.hop_done);
                    mismatches++;
                end
                if (outcome_ch.hop_kind !== exp_out.hop_kind)
                begin
                    $error("hop_kind: expected %0d, got %0d",
                           exp_out.hop_kind, outcome_ch.hop_kind);
                    mismatches++;
                end
                if (outcome_ch.current_col !== exp_out.current_col)
                begin
                    $error("current_col: expected %0d, got %0d",
                           exp_out.current_col, outcome_ch.current_col);
                    mismatches++;
                end
                if (outcome_ch.energy_delta !== exp_out.energy_delta)
                begin
                    $error("energy_delta: expected %0d, got %0d",
                           exp_out.energy_delta, outcome_ch.energy_delta);
                    mismatches++;
                end
            end
        end
    end

    // apply one move attempt to the shadow lattice and return its outcome
    function automatic hop_outcome_t predict_hop(input logic [SITE_ROW_W-1:0] row,
                                                 input logic [SITE_COL_W-1:0] col,
                                                 input hop_dir_t dir,
                                                 input logic [FRAC_W-1:0] frac);
        hop_outcome_t res;
        int r, c, cw, ce, tgt, opp, beyond, e_from, e_to, delta;
        bit hot, take;
        res = NO_HOP;
        r = int'(row);
        c = int'(col);
        cw = (c + COLS - 1) % COLS;
        ce = (c + 1) % COLS;
        if (occ[r][c])
        begin
            if (dir == DIR_RIGHT)
            begin
                // infinite drive: always taken when the neighbor is free
                if (!occ[r][ce])
                begin
                    occ[r][c] = 1'b0;
                    occ[r][ce] = 1'b1;
                    res.hop_done = 1'b1;
                    res.hop_kind = KIND_RIGHT;
                    res.current_col = col;
                    right_hops++;
                end
            end
            else if (dir == DIR_UP || dir == DIR_DOWN)
            begin
                // row 0 is the top; up is row - 1, both wrap
                tgt    = (dir == DIR_UP) ? (r + ROWS - 1) % ROWS : (r + 1) % ROWS;
                opp    = (dir == DIR_UP) ? (r + 1) % ROWS : (r + ROWS - 1) % ROWS;
                beyond = (dir == DIR_UP) ? (tgt + ROWS - 1) % ROWS : (tgt + 1) % ROWS;
                if (!occ[tgt][c])
                begin
                    e_from = int'(occ[opp][c]) + int'(occ[r][cw]) + int'(occ[r][ce]);
                    e_to = int'(occ[beyond][c]) + int'(occ[tgt][cw]) + int'(occ[tgt][ce]);
                    delta = e_to - e_from;
                    res.energy_delta = delta[DELTA_W-1:0];
                    hot = (col >= band_first) && (col < band_end);
                    if (delta >= 0)
                        take = 1'b1;
                    else if (hot)
                        take = frac < prob_high[-delta - 1];
                    else
                        take = frac < prob_low[-delta - 1];
                    if (take)
                    begin
                        occ[r][c] = 1'b0;
                        occ[tgt][c] = 1'b1;
                        res.hop_done = 1'b1;
                        res.hop_kind = (dir == DIR_UP) ? KIND_UP : KIND_DOWN;
                        res.current_col = col;
                        vert_hops++;
                        if (delta < 0)
                            uphill_takes++;
                    end
                    else
                    begin
                        vert_refusals++;
                    end
                end
            end
        end
        return res;
    endfunction

    // offer one attempt; returns at the falling edge after its transfer
    task automatic send_attempt(input logic [SITE_ROW_W-1:0] row,
                                input logic [SITE_COL_W-1:0] col,
                                input hop_dir_t dir,
                                input logic [FRAC_W-1:0] frac,
                                input bit typed,
                                input hop_outcome_t want);
        hop_outcome_t pred;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            move_ch.valid <= 1'b0;
            @(negedge clk);
        end
        move_ch.valid     <= 1'b1;
        move_ch.site_row  <= row;
        move_ch.site_col  <= col;
        move_ch.hop_dir   <= dir;
        move_ch.rand_frac <= frac;
        do @(posedge clk); while (!move_ch.ready);
        pred = predict_hop(row, col, dir, frac);
        hop_outcomes_due.push_back(typed ? want : pred);
        attempts++;
        @(negedge clk);
    endtask

    // stop offering attempts until every outcome has been returned
    task automatic settle();
        move_ch.valid <= 1'b0;
        do @(negedge clk); while (hop_outcomes_due.size() != 0);
    endtask

    // one register write; leaves valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        reg_ch.valid <= 1'b1;
        reg_ch.idx   <= idx;
        reg_ch.wdata <= data;
        do @(posedge clk); while (!reg_ch.ready);
        case (idx)
            REG_PROB_LOW_M1:  prob_low[0]  = data;
            REG_PROB_LOW_M2:  prob_low[1]  = data;
            REG_PROB_LOW_M3:  prob_low[2]  = data;
            REG_PROB_HIGH_M1: prob_high[0] = data;
            REG_PROB_HIGH_M2: prob_high[1] = data;
            REG_PROB_HIGH_M3: prob_high[2] = data;
            REG_BAND_FIRST:   band_first   = data[BAND_W-1:0];
            REG_BAND_END:     band_end     = data[BAND_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
    endtask

    // full register set plus one write to an unmapped index
    task automatic apply_setting(input logic [FRAC_W-1:0] lo1, lo2, lo3,
                                 input logic [FRAC_W-1:0] hi1, hi2, hi3,
                                 input logic [CFG_DATA_W-1:0] first_col, stop_col);
        write_reg(REG_PROB_LOW_M1, lo1);
        write_reg(REG_PROB_LOW_M2, lo2);
        write_reg(REG_PROB_LOW_M3, lo3);
        write_reg(CFG_IDX_SPARE + CFG_IDX_W'($urandom_range(0, 7)), $urandom);
        write_reg(REG_PROB_HIGH_M1, hi1);
        write_reg(REG_PROB_HIGH_M2, hi2);
        write_reg(REG_PROB_HIGH_M3, hi3);
        write_reg(REG_BAND_FIRST, first_col);
        write_reg(REG_BAND_END, stop_col);
        reg_ch.valid <= 1'b0;
    endtask

    // random attempts concentrated in a small moving window so the lattice
    // departs from the checkerboard and all bond changes show up
    task automatic run_phase(input int s_gap, input int r_gap, input int band_center,
                             input bit hold_midway);
        int live, since_move, win_row, win_col, tries, sel, k;
        bit fill, held;
        logic [SITE_ROW_W-1:0] row;
        logic [SITE_COL_W-1:0] col;
        hop_dir_t              dir;
        logic [FRAC_W-1:0]     frac;
        send_gap_pct = s_gap;
        recv_gap_pct = r_gap;
        live = 0;
        since_move = WIN * WIN;
        held = 1'b0;
        win_row = 0;
        win_col = 0;
        while (live < PHASE_HOPS)
        begin
            if (since_move >= WIN * WIN)
            begin
                since_move = 0;
                win_row = $urandom_range(0, ROWS - 1);
                if (band_center < 0)
                    win_col = $urandom_range(0, COLS - 1);
                else
                    win_col = (band_center - 3 + $urandom_range(0, 3) + COLS) % COLS;
            end
            if (hold_midway && !held && live == PHASE_HOPS / 2)
            begin
                settle();
                held = 1'b1;
            end

            sel = $urandom_range(0, 99);
            if (sel < 30)
                dir = DIR_RIGHT;
            else if (sel < 38)
                dir = DIR_LEFT;
            else if (sel < 69)
                dir = DIR_UP;
            else
                dir = DIR_DOWN;

            // site: mostly an occupied one in the window, some anywhere
            if ($urandom_range(0, 9) == 0)
            begin
                row = SITE_ROW_W'($urandom_range(0, ROWS - 1));
                col = SITE_COL_W'($urandom_range(0, COLS - 1));
            end
            else
            begin
                fill = ($urandom_range(0, 4) != 0);
                tries = 0;
                do
                begin
                    row = SITE_ROW_W'((win_row + $urandom_range(0, WIN - 1)) % ROWS);
                    col = SITE_COL_W'((win_col + $urandom_range(0, WIN - 1)) % COLS);
                    tries++;
                end
                while (fill && !occ[row][col] && tries < 12);
            end

            // random fraction: extremes, values around a threshold, uniform
            sel = $urandom_range(0, 99);
            if (sel < 12)
                frac = '0;
            else if (sel < 22)
                frac = FRAC_MAX;
            else if (sel < 50)
            begin
                k = $urandom_range(0, 2 * NUM_PROB - 1);
                frac = (k < NUM_PROB) ? prob_low[k] : prob_high[k - NUM_PROB];
                frac = frac + FRAC_W'($urandom_range(0, 2)) - 1'b1;
            end
            else
                frac = $urandom;

            if (occ[row][col] && dir != DIR_LEFT)
            begin
                live++;
                since_move++;
            end
            send_attempt(row, col, dir, frac, 1'b0, NO_HOP);
        end
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        move_ch.valid = 1'b0;
        move_ch.site_row = '0;
        move_ch.site_col = '0;
        move_ch.hop_dir = DIR_RIGHT;
        move_ch.rand_frac = '0;
        outcome_ch.ready = 1'b0;
        reg_ch.valid = 1'b0;
        reg_ch.idx = REG_PROB_LOW_M1;
        reg_ch.wdata = '0;
        send_gap_pct = 16;
        recv_gap_pct = 85;
        mismatches = 0;
        attempts = 0;
        outcomes_checked = 0;
        right_hops = 0;
        vert_hops = 0;
        uphill_takes = 0;
        vert_refusals = 0;

        // shadow state after reset: checkerboard, default registers
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                occ[r][c] = ((r + c) % 2 == 0);
        prob_low[0]  = PROB_LOW_M1_RST;
        prob_low[1]  = PROB_LOW_M2_RST;
        prob_low[2]  = PROB_LOW_M3_RST;
        prob_high[0] = PROB_HIGH_M1_RST;
        prob_high[1] = PROB_HIGH_M2_RST;
        prob_high[2] = PROB_HIGH_M3_RST;
        band_first   = '0;
        band_end     = '0;

        // directed attempts on the fresh checkerboard, default registers
        directed_rows = '{
            // right hop from the corner
            '{7'd0,   10'd0,    DIR_RIGHT, 32'h0,    1'b1, '{1'b1, KIND_RIGHT, 10'd0, 3'sd0}},
            // the corner is now empty
            '{7'd0,   10'd0,    DIR_RIGHT, FRAC_MAX, 1'b1, NO_HOP},
            // left is ignored even on an occupied site
            '{7'd0,   10'd1,    DIR_LEFT,  FRAC_MAX, 1'b1, NO_HOP},
            // right neighbor occupied: blocked, no current
            '{7'd0,   10'd1,    DIR_RIGHT, 32'h0,    1'b1, NO_HOP},
            // right hop across the column wrap
            '{7'd127, 10'd1023, DIR_RIGHT, 32'h0,    1'b1,
              '{1'b1, KIND_RIGHT, 10'd1023, 3'sd0}},
            '{7'd127, 10'd1023, DIR_DOWN,  FRAC_MAX, 1'b1, NO_HOP},
            // down across the row wrap into an occupied site
            '{7'd127, 10'd1,    DIR_DOWN,  32'h0,    1'b1, NO_HOP},
            '{7'd127, 10'd0,    DIR_UP,    32'h0,    1'b1, NO_HOP},
            // checkerboard vertical hop: bond change +3, always taken
            '{7'd20,  10'd20,   DIR_UP,    FRAC_MAX, 1'b1, '{1'b1, KIND_UP, 10'd20, 3'sd3}},
            // hop back down costs 3 bonds: fraction equal to threshold, then just below
            '{7'd19,  10'd20,   DIR_DOWN,  PROB_LOW_M3_RST,        1'b0, NO_HOP},
            '{7'd19,  10'd20,   DIR_DOWN,  PROB_LOW_M3_RST - 1'b1, 1'b0, NO_HOP},
            // vertical hop whose neighbor column wraps
            '{7'd31,  10'd1023, DIR_UP,    32'h0,    1'b1, '{1'b1, KIND_UP, 10'd1023, 3'sd3}},
            // up from the top row wraps to the bottom row
            '{7'd0,   10'd4,    DIR_UP,    FRAC_MAX, 1'b1, '{1'b1, KIND_UP, 10'd4, 3'sd3}},
            '{7'd127, 10'd4,    DIR_DOWN,  32'h7FFF_FFFF, 1'b0, NO_HOP},
            '{7'd127, 10'd7,    DIR_DOWN,  32'h0,    1'b1, '{1'b1, KIND_DOWN, 10'd7, 3'sd3}},
            '{7'd50,  10'd50,   DIR_LEFT,  32'h0,    1'b1, NO_HOP}
        };

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first attempt waits out the lattice sweep through item.ready
        foreach (directed_rows[i])
            send_attempt(directed_rows[i].row, directed_rows[i].col, directed_rows[i].dir,
                         directed_rows[i].frac, directed_rows[i].typed,
                         directed_rows[i].want);
        settle();

        // narrow hot band; uphill never outside it, inside unless the fraction is all ones
        apply_setting('0, '0, '0, FRAC_MAX, FRAC_MAX, FRAC_MAX, 32'd300, 32'd304);
        run_phase(16, 85, 300, 1'b1);

        // whole lattice hot; upper bits of the band write must be dropped
        apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      32'hFFFF_F800, 32'd1024);
        run_phase(85, 16, -1, 1'b0);

        // inverted band: nothing hot
        apply_setting(FRAC_MAX, FRAC_MAX, FRAC_MAX, '0, '0, '0, 32'd2047, 32'd5);
        run_phase(0, 0, 3, 1'b0);

        // band at the right edge of the lattice
        apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      32'd1020, 32'd1024);
        run_phase(0, 0, 1021, 1'b0);

        // let any late result show up
        repeat (20) @(negedge clk);

        $display("covered %0d attempts: %0d right, %0d vertical hops (%0d uphill), %0d refused",
                 attempts, right_hops, vert_hops, uphill_takes, vert_refusals);
        $display("empty, full, inverted and edge hot bands; %0d results, %0d mismatches",
                 outcomes_checked, mismatches);
        if (mismatches == 0 && hop_outcomes_due.size() == 0)
            $display("driven_lattice_gas_metropolis_unit regression: pass");
        else
            $display("driven_lattice_gas_metropolis_unit regression: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/dlg_pkg.sv
design/dlg_ifs.sv
design/dlg_ram.sv
design/dlg_cfg_regs.sv
design/dlg_addr_gen.sv
design/dlg_seq.sv
design/driven_lattice_gas_metropolis_unit.sv
verif/testbench.sv
